FILE: rtl/core/s2m_pkg.sv
// Package with the payload types and constants of the stereo-to-mono resampler.
package s2m_pkg;

    localparam int unsigned SampleW = 16;
    localparam int unsigned PhaseW = 16;

    localparam logic [PhaseW-1:0] StepReset = 16'd47555;
    localparam logic [PhaseW-1:0] StepFloor = 16'd1024;

    typedef struct packed {
        logic signed [SampleW-1:0] left_sample;
        logic signed [SampleW-1:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SampleW-1:0] mono_sample;
        logic                      last_of_run;
    } t_out_item;

endpackage

FILE: rtl/core/stereo_to_mono_linear_resampler.sv
// Stereo-to-mono linear-interpolation resampler with one shared multiplier.
// The first result of an item passes the operand registers and the product register on
// its way to the output register. Each result takes a multiply step and an emit step through
// the single multiplier. Emit waits on a full, unread output; a new item waits for idle.
// Reset (synchronous, active low): phase and previous sample clear to zero, the step
// register returns to 47555, and the output register is emptied.
module stereo_to_mono_linear_resampler
    import s2m_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [PhaseW-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [PhaseW-1:0]          r_phase_step;
    logic [PhaseW:0]            r_acc;
    logic [PhaseW-1:0]          r_phase;
    logic signed [SampleW-1:0]  r_prev;
    logic signed [SampleW-1:0]  r_cur;
    logic signed [SampleW:0]    r_diff;
    logic signed [2*SampleW+1:0] r_prod;
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic signed [SampleW:0]    sum;
    logic signed [SampleW-1:0]  cur;
    logic [PhaseW-1:0]          step;
    logic [PhaseW:0]            acc_next;
    logic signed [SampleW:0]    quot;
    logic signed [SampleW:0]    interp;
    logic                       in_acc;
    logic                       out_free;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign sum  = {i_in_data.left_sample[SampleW-1], i_in_data.left_sample}
                + {i_in_data.right_sample[SampleW-1], i_in_data.right_sample};
    assign cur  = sum[SampleW:1];
    assign step = (r_phase_step < StepFloor) ? StepFloor : r_phase_step;
    assign acc_next = r_acc + {1'b0, step};
    // Floor shift of the product by 16 places.
    assign quot   = r_prod[2*SampleW:PhaseW];
    assign interp = {r_prev[SampleW-1], r_prev} + quot;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_MUL;
            S_MUL:  n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) n_state = acc_next[PhaseW] ? S_IDLE : S_MUL;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase_step <= StepReset;
            r_phase      <= '0;
            r_prev       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_phase_step <= i_cfg_data;
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
                if (acc_next[PhaseW]) begin
                    r_phase <= acc_next[PhaseW-1:0];
                    r_prev  <= r_cur;
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_cur  <= cur;
                    r_diff <= {cur[SampleW-1], cur} - {r_prev[SampleW-1], r_prev};
                    r_acc  <= {1'b0, r_phase};
                end
            end
            S_MUL: begin
                r_prod <= (2*SampleW+2)'(r_diff)
                        * (2*SampleW+2)'($signed({1'b0, r_acc[PhaseW-1:0]}));
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out.mono_sample <= interp[SampleW-1:0];
                    r_out.last_of_run <= acc_next[PhaseW];
                    r_acc             <= acc_next;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/s2m_checker.sv
// Port-level checker for the stereo-to-mono resampler and its bind to the resampler module.
module s2m_checker
    import s2m_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_we,
    input logic [PhaseW-1:0] i_cfg_data,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input t_in_item          i_in_data,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input t_out_item         o_out_data
);

    // An accepted item always produces work, so the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    // While idle, any result still waiting must be the last one of its run.
    a_idle_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_in_ready) |-> o_out_data.last_of_run)
        else $error("idle with a run still open");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

endmodule

bind stereo_to_mono_linear_resampler s2m_checker u_s2m_checker (.*);

FILE: test/stereo_to_mono_linear_resampler_tb.sv
// Testbench for the stereo-to-mono resampler: predicting scoreboard, random handshakes and steps.
`timescale 1ns / 100ps

module stereo_to_mono_linear_resampler_tb;
    import s2m_pkg::*;

    // Expected mono outputs, worked out from each accepted stereo pair.
    class resample_scoreboard;
        t_out_item         mono_q[$];
        logic [PhaseW-1:0] step;
        logic [PhaseW-1:0] phase;
        int                prev_mono;
        int                mismatches;
        int                pairs_seen;
        int                outputs_checked;

        function new();
            step = StepReset;
            phase = '0;
            prev_mono = 0;
            mismatches = 0;
            pairs_seen = 0;
            outputs_checked = 0;
        endfunction

        function void set_step(logic [PhaseW-1:0] value);
            step = value;
        endfunction

        function int pending();
            return mono_q.size();
        endfunction

        function void note_pair(t_in_item pair);
            int          sum;
            int          cur;
            int          y;
            int unsigned eff_step;
            int unsigned acc;
            longint      prod;
            t_out_item   e;
            sum = int'($signed(pair.left_sample)) + int'($signed(pair.right_sample));
            cur = sum >>> 1;
            eff_step = (step < StepFloor) ? int'(StepFloor) : int'(step);
            acc = 32'(phase);
            while (acc < 32'h1_0000) begin
                prod = longint'(cur - prev_mono) * longint'(acc);
                y = prev_mono + int'(prod >>> 16);
                e.mono_sample = y[15:0];
                e.last_of_run = 1'b0;
                mono_q = {mono_q, e};
                acc += eff_step;
            end
            mono_q[mono_q.size() - 1].last_of_run = 1'b1;
            phase = acc[PhaseW-1:0];
            prev_mono = cur;
            pairs_seen++;
        endfunction

        function void check_mono(t_out_item got);
            t_out_item e;
            outputs_checked++;
            if (mono_q.size() == 0) begin
                $error("unexpected item: mono_sample %0d, last_of_run %0b",
                       got.mono_sample, got.last_of_run);
                mismatches++;
                return;
            end
            e = mono_q.pop_front();
            if (got.mono_sample !== e.mono_sample) begin
                $error("mono_sample: expected %0d, got %0d", e.mono_sample, got.mono_sample);
                mismatches++;
            end
            if (got.last_of_run !== e.last_of_run) begin
                $error("last_of_run: expected %0b, got %0b", e.last_of_run, got.last_of_run);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [PhaseW-1:0] cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    t_in_item          in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_item         out_data;

    resample_scoreboard sb = new();
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit long_hold_req = 1'b0;
    int step_settings = 1;

    stereo_to_mono_linear_resampler uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one stereo pair and returns at the edge where it is accepted.
    // Valid stays high between back-to-back items.
    task automatic send_pair(input logic [15:0] left, input logic [15:0] right);
        int gap;
        t_in_item pair;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        pair.left_sample = left;
        pair.right_sample = right;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= pair;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_pair(pair);
    endtask

    task automatic send_random(input int count);
        logic [15:0] left;
        logic [15:0] right;
        int mode;
        repeat (count) begin
            mode = $urandom_range(0, 9);
            left = 16'($urandom());
            right = 16'($urandom());
            if (mode inside {[6:7]}) begin
                // Quiet signal near zero, where rounding toward minus infinity shows.
                left = 16'($urandom_range(0, 255) - 128);
                right = 16'($urandom_range(0, 255) - 128);
            end else if (mode == 8) begin
                left = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                right = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end else if (mode == 9) begin
                right = left;
            end
            send_pair(left, right);
        end
    endtask

    // Drops valid and waits until every expected output has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_step(input logic [PhaseW-1:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_step(value);
        step_settings++;
    endtask

    // Output side: random ready gaps, plus one long hold-off on request.
    initial begin
        int gap;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            gap = rx_steady ? 0 : $urandom_range(0, 9);
            if (long_hold_req) begin
                gap = 400;
                long_hold_req = 1'b0;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            sb.check_mono(out_data);
        end
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default step straight out of reset: sample extremes and rounding corners.
        send_pair(16'h7FFF, 16'h7FFF);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h0000, 16'h0000);
        send_pair(16'hFFFF, 16'h0000);
        send_pair(16'hFFFF, 16'hFFFF);
        send_pair(16'h0001, 16'h0000);
        send_pair(16'h5555, 16'hAAAA);
        send_pair(16'hAAAA, 16'h5555);
        send_pair(16'h7FFF, 16'h7FFF);
        send_pair(16'h8000, 16'h8000);
        send_random(40);

        // A zero step is clamped to the floor, so every pair after the first gives 64 outputs.
        write_step(16'd0);
        send_pair(16'h7FFF, 16'h7FFF);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h7FFF, 16'h7FFF);
        send_pair(16'h0000, 16'hFFFF);

        // Largest step with no idling on either side.
        write_step(16'hFFFF);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        send_random(30);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        write_step(StepFloor);
        send_random(3);

        write_step(16'd1023);
        send_random(2);

        // Exact half step while the output side stalls long enough to back up the input.
        write_step(16'h8000);
        long_hold_req = 1'b1;
        tx_steady = 1'b1;
        send_random(25);
        tx_steady = 1'b0;

        repeat (3) begin
            write_step(16'($urandom_range(16000, 65535)));
            send_random(15);
        end

        write_step(StepReset);
        send_random(20);

        drain();
        repeat (20) @(posedge clk);
        $display("Covered %0d stereo pairs and %0d mono outputs over %0d step settings.",
                 sb.pairs_seen, sb.outputs_checked, step_settings);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
